>>> hdl/vsc_pkg.sv
// Shared types, constants and helpers for the Verlet stick constraint core.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none
package vsc_pkg;

  localparam int IDX_W             = 10;
  localparam int DATA_W            = 32;
  localparam int CNT_W             = 11;
  localparam int OP_W              = 2;
  localparam int STAT_W            = 2;
  localparam int DEF_MAX_PARTICLES = 1024;
  localparam int DEF_FRAC_BITS     = 16;
  localparam int QUEUE_DEPTH       = 2;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STICK = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE      = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_TOO_CLOSE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_STICK,
    CMD_SKIP,
    CMD_REJECT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic [IDX_W-1:0]          index_a;
    logic [IDX_W-1:0]          index_b;
    logic signed [DATA_W-1:0]  value_x;
    logic signed [DATA_W-1:0]  value_y;
    logic [DATA_W-1:0]         stick_length;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

  typedef enum logic [4:0] {
    BK_IDLE,
    BK_EXEC,
    BK_READ_OUT,
    BK_READ_B,
    BK_DIFF,
    BK_MAG,
    BK_SQUARE,
    BK_SUM,
    BK_SQRT,
    BK_CHECK,
    BK_DMAG,
    BK_PROD_LO,
    BK_PROD_HI,
    BK_DIV_INIT,
    BK_DIV,
    BK_APPLY,
    BK_WRITE_A,
    BK_WRITE_B
  } bk_state_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [42:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 43'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -43'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/verlet_stick_constraint_core.sv
// Every accepted request gets one out_strobe: write, rejected and unused requests, a read,
// a stick rejected as too close and a relaxed stick (32-step square root, then 40-step
// divide on X and Y lanes in parallel). The back end takes a new request only once it has
// finished the last; two more can wait in the command queue and busy is high while it is
// full. Results cannot be stalled. Synchronous reset clears particle_count and the queue;
// position memories are unknown until written.
`default_nettype none
module verlet_stick_constraint_core #(
  parameter int MAX_PARTICLES = vsc_pkg::DEF_MAX_PARTICLES,
  parameter int FRAC_BITS     = vsc_pkg::DEF_FRAC_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [vsc_pkg::OP_W-1:0]          in_operation,
  input  wire logic [vsc_pkg::IDX_W-1:0]         in_index_a,
  input  wire logic [vsc_pkg::IDX_W-1:0]         in_index_b,
  input  wire logic signed [vsc_pkg::DATA_W-1:0] in_value_x,
  input  wire logic signed [vsc_pkg::DATA_W-1:0] in_value_y,
  input  wire logic [vsc_pkg::DATA_W-1:0]        in_stick_length,
  output logic                                   out_strobe,
  output logic signed [vsc_pkg::DATA_W-1:0]      out_read_x,
  output logic signed [vsc_pkg::DATA_W-1:0]      out_read_y,
  output logic [vsc_pkg::STAT_W-1:0]             out_status,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [2:0]                        cfg_paddr,
  input  wire logic [31:0]                       cfg_pwdata,
  output logic [31:0]                            cfg_prdata,
  output logic                                   cfg_pready
);

  logic [vsc_pkg::CNT_W-1:0] particle_count_r;
  vsc_pkg::queue_status_t    q_status;
  vsc_pkg::cmd_t             push_cmd;
  vsc_pkg::cmd_t             head_cmd;
  logic                      push;
  logic                      pop;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? 32'(particle_count_r) : '0;
  assign busy       = q_status.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      particle_count_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == 1'b0)) begin
      particle_count_r <= cfg_pwdata[vsc_pkg::CNT_W-1:0];
    end
  end

  vsc_front #(
    .MAX_PARTICLES(MAX_PARTICLES)
  ) u_front (
    .start          (start),
    .q_status       (q_status),
    .in_operation   (in_operation),
    .in_index_a     (in_index_a),
    .in_index_b     (in_index_b),
    .in_value_x     (in_value_x),
    .in_value_y     (in_value_y),
    .in_stick_length(in_stick_length),
    .particle_count (particle_count_r),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  vsc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .q_status(q_status),
    .head_cmd(head_cmd)
  );

  vsc_back #(
    .MAX_PARTICLES(MAX_PARTICLES),
    .FRAC_BITS    (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .out_strobe(out_strobe),
    .out_read_x(out_read_x),
    .out_read_y(out_read_y),
    .out_status(out_status)
  );

endmodule
`default_nettype wire

>>> hdl/vsc_front.sv
// Front end: accepts requests and classifies them by operation and index range.
// Depends on vsc_pkg; feeds classified commands into vsc_queue.
`default_nettype none
module vsc_front #(
  parameter int MAX_PARTICLES = vsc_pkg::DEF_MAX_PARTICLES
) (
  input  wire logic                        start,
  input  wire vsc_pkg::queue_status_t      q_status,
  input  wire logic [vsc_pkg::OP_W-1:0]    in_operation,
  input  wire logic [vsc_pkg::IDX_W-1:0]   in_index_a,
  input  wire logic [vsc_pkg::IDX_W-1:0]   in_index_b,
  input  wire logic signed [vsc_pkg::DATA_W-1:0] in_value_x,
  input  wire logic signed [vsc_pkg::DATA_W-1:0] in_value_y,
  input  wire logic [vsc_pkg::DATA_W-1:0]  in_stick_length,
  input  wire logic [vsc_pkg::CNT_W-1:0]   particle_count,
  output logic                             push,
  output vsc_pkg::cmd_t                    push_cmd
);

  logic ok_a;
  logic ok_b;

  assign ok_a = (32'(in_index_a) < 32'(particle_count)) &&
                (32'(in_index_a) < 32'(MAX_PARTICLES));
  assign ok_b = (32'(in_index_b) < 32'(particle_count)) &&
                (32'(in_index_b) < 32'(MAX_PARTICLES));

  assign push = start && !q_status.full;

  always_comb begin
    push_cmd.index_a      = in_index_a;
    push_cmd.index_b      = in_index_b;
    push_cmd.value_x      = in_value_x;
    push_cmd.value_y      = in_value_y;
    push_cmd.stick_length = in_stick_length;
    unique case (vsc_pkg::op_t'(in_operation))
      vsc_pkg::OP_WRITE: push_cmd.kind = ok_a ? vsc_pkg::CMD_WRITE : vsc_pkg::CMD_REJECT;
      vsc_pkg::OP_READ:  push_cmd.kind = ok_a ? vsc_pkg::CMD_READ : vsc_pkg::CMD_REJECT;
      vsc_pkg::OP_STICK: push_cmd.kind = (ok_a && ok_b) ? vsc_pkg::CMD_STICK
                                                        : vsc_pkg::CMD_REJECT;
      default:           push_cmd.kind = vsc_pkg::CMD_SKIP;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/vsc_queue.sv
// Short command queue between the front end and the back end.
// Depends on vsc_pkg for the command type and depth.
`default_nettype none
module vsc_queue (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire vsc_pkg::cmd_t          push_cmd,
  input  wire logic                   pop,
  output vsc_pkg::queue_status_t      q_status,
  output vsc_pkg::cmd_t               head_cmd
);

  localparam int PTR_W = (vsc_pkg::QUEUE_DEPTH > 1) ? $clog2(vsc_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(vsc_pkg::QUEUE_DEPTH + 1);

  vsc_pkg::cmd_t      entry_r [vsc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0]  count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign q_status.valid = (count_r != '0);
  assign q_status.full  = (count_r == CNT_QW'(vsc_pkg::QUEUE_DEPTH));
  assign head_cmd       = entry_r[rd_ptr_r];
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && q_status.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(vsc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(vsc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

>>> hdl/vsc_back.sv
// Back end: position memories, square root and divide sequencer, result output.
// Depends on vsc_pkg; takes commands from vsc_queue.
`default_nettype none
module vsc_back #(
  parameter int MAX_PARTICLES = vsc_pkg::DEF_MAX_PARTICLES,
  parameter int FRAC_BITS     = vsc_pkg::DEF_FRAC_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire vsc_pkg::queue_status_t      q_status,
  input  wire vsc_pkg::cmd_t               head_cmd,
  output logic                             pop,
  output logic                             out_strobe,
  output logic signed [vsc_pkg::DATA_W-1:0] out_read_x,
  output logic signed [vsc_pkg::DATA_W-1:0] out_read_y,
  output logic [vsc_pkg::STAT_W-1:0]       out_status
);

  localparam int AW = $clog2(MAX_PARTICLES);
  localparam longint MIN_DIST = ((64'd1 << FRAC_BITS) + 64'd999) / 64'd1000;

  vsc_pkg::bk_state_t state_r, state_nxt;
  vsc_pkg::cmd_t      cmd_r;

  logic signed [31:0] mem_x [MAX_PARTICLES];
  logic signed [31:0] mem_y [MAX_PARTICLES];
  logic signed [31:0] rd_x_r, rd_y_r;

  logic               mem_we, mem_re;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic signed [31:0] wr_x, wr_y;
  logic               emit;
  vsc_pkg::status_t   emit_status;
  logic               emit_data;

  logic signed [31:0] xa_r, ya_r, xb_r, yb_r;
  logic signed [32:0] dx_r, dy_r;
  logic [31:0]        adx_r, ady_r;
  logic               ngx_r, ngy_r, sh_r;
  logic [30:0]        mx_r, my_r;
  logic [61:0]        sqx_r, sqy_r;
  logic [62:0]        rad_r, root_r, bit_r;
  logic [5:0]         cnt_r;
  logic signed [33:0] diff_r;
  logic [33:0]        den_r;
  logic [32:0]        dmag_r;
  logic               dneg_r;
  logic [48:0]        plx_r, ply_r;
  logic [65:0]        prx_r, pry_r;
  logic [33:0]        remx_r, remy_r;
  logic [39:0]        qx_r, qy_r;
  logic               ovx_r, ovy_r;
  logic signed [31:0] nxa_r, nya_r, nxb_r, nyb_r;

  logic [32:0]        adx_w, ady_w;
  logic               sh_w;
  logic [63:0]        sq_t;
  logic [32:0]        dist_w;
  logic               too_close;
  logic [34:0]        tx, ty;
  logic               gx, gy;
  logic [40:0]        qfx, qfy;
  logic signed [41:0] ox, oy;

  assign adx_w = dx_r[32] ? 33'(-dx_r) : 33'(dx_r);
  assign ady_w = dy_r[32] ? 33'(-dy_r) : 33'(dy_r);
  assign sh_w  = adx_w[31] || ady_w[31];
  assign sq_t  = {1'b0, root_r} + {1'b0, bit_r};
  assign dist_w = 33'(root_r[31:0]) << sh_r;
  assign too_close = (dist_w < 33'(MIN_DIST));
  assign tx = {remx_r, prx_r[39]};
  assign ty = {remy_r, pry_r[39]};
  assign gx = (tx >= {1'b0, den_r});
  assign gy = (ty >= {1'b0, den_r});
  assign qfx = ovx_r ? (41'd1 << 40) : {1'b0, qx_r};
  assign qfy = ovy_r ? (41'd1 << 40) : {1'b0, qy_r};
  assign ox  = (ngx_r ^ dneg_r) ? -$signed({1'b0, qfx}) : $signed({1'b0, qfx});
  assign oy  = (ngy_r ^ dneg_r) ? -$signed({1'b0, qfy}) : $signed({1'b0, qfy});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vsc_pkg::BK_IDLE: begin
        if (q_status.valid) begin
          state_nxt = vsc_pkg::BK_EXEC;
        end
      end
      vsc_pkg::BK_EXEC: begin
        unique case (cmd_r.kind)
          vsc_pkg::CMD_READ:  state_nxt = vsc_pkg::BK_READ_OUT;
          vsc_pkg::CMD_STICK: state_nxt = vsc_pkg::BK_READ_B;
          default:            state_nxt = vsc_pkg::BK_IDLE;
        endcase
      end
      vsc_pkg::BK_READ_OUT: state_nxt = vsc_pkg::BK_IDLE;
      vsc_pkg::BK_READ_B:   state_nxt = vsc_pkg::BK_DIFF;
      vsc_pkg::BK_DIFF:     state_nxt = vsc_pkg::BK_MAG;
      vsc_pkg::BK_MAG:      state_nxt = vsc_pkg::BK_SQUARE;
      vsc_pkg::BK_SQUARE:   state_nxt = vsc_pkg::BK_SUM;
      vsc_pkg::BK_SUM:      state_nxt = vsc_pkg::BK_SQRT;
      vsc_pkg::BK_SQRT: begin
        if (cnt_r == '0) begin
          state_nxt = vsc_pkg::BK_CHECK;
        end
      end
      vsc_pkg::BK_CHECK:    state_nxt = too_close ? vsc_pkg::BK_IDLE : vsc_pkg::BK_DMAG;
      vsc_pkg::BK_DMAG:     state_nxt = vsc_pkg::BK_PROD_LO;
      vsc_pkg::BK_PROD_LO:  state_nxt = vsc_pkg::BK_PROD_HI;
      vsc_pkg::BK_PROD_HI:  state_nxt = vsc_pkg::BK_DIV_INIT;
      vsc_pkg::BK_DIV_INIT: state_nxt = vsc_pkg::BK_DIV;
      vsc_pkg::BK_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = vsc_pkg::BK_APPLY;
        end
      end
      vsc_pkg::BK_APPLY:    state_nxt = vsc_pkg::BK_WRITE_A;
      vsc_pkg::BK_WRITE_A:  state_nxt = vsc_pkg::BK_WRITE_B;
      vsc_pkg::BK_WRITE_B:  state_nxt = vsc_pkg::BK_IDLE;
      default:              state_nxt = vsc_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop         = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    wr_addr     = AW'(cmd_r.index_a);
    rd_addr     = AW'(cmd_r.index_a);
    wr_x        = cmd_r.value_x;
    wr_y        = cmd_r.value_y;
    emit        = 1'b0;
    emit_status = vsc_pkg::ST_DONE;
    emit_data   = 1'b0;
    unique case (state_r)
      vsc_pkg::BK_IDLE: pop = q_status.valid;
      vsc_pkg::BK_EXEC: begin
        unique case (cmd_r.kind)
          vsc_pkg::CMD_WRITE: begin
            mem_we = 1'b1;
            emit   = 1'b1;
          end
          vsc_pkg::CMD_READ:   mem_re = 1'b1;
          vsc_pkg::CMD_STICK:  mem_re = 1'b1;
          vsc_pkg::CMD_REJECT: begin
            emit        = 1'b1;
            emit_status = vsc_pkg::ST_BAD_INDEX;
          end
          default: emit = 1'b1;
        endcase
      end
      vsc_pkg::BK_READ_OUT: begin
        emit      = 1'b1;
        emit_data = 1'b1;
      end
      vsc_pkg::BK_READ_B: begin
        mem_re  = 1'b1;
        rd_addr = AW'(cmd_r.index_b);
      end
      vsc_pkg::BK_CHECK: begin
        if (too_close) begin
          emit        = 1'b1;
          emit_status = vsc_pkg::ST_TOO_CLOSE;
        end
      end
      vsc_pkg::BK_WRITE_A: begin
        mem_we = 1'b1;
        wr_x   = nxa_r;
        wr_y   = nya_r;
      end
      vsc_pkg::BK_WRITE_B: begin
        mem_we  = 1'b1;
        wr_addr = AW'(cmd_r.index_b);
        wr_x    = nxb_r;
        wr_y    = nyb_r;
        emit    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
    end
    if (mem_re) begin
      rd_x_r <= mem_x[rd_addr];
      rd_y_r <= mem_y[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= vsc_pkg::BK_IDLE;
      out_strobe <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      out_strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status <= emit_status;
      out_read_x <= emit_data ? rd_x_r : '0;
      out_read_y <= emit_data ? rd_y_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= head_cmd;
    end
    unique case (state_r)
      vsc_pkg::BK_READ_B: begin
        xa_r <= rd_x_r;
        ya_r <= rd_y_r;
      end
      vsc_pkg::BK_DIFF: begin
        xb_r <= rd_x_r;
        yb_r <= rd_y_r;
        dx_r <= 33'(rd_x_r) - 33'(xa_r);
        dy_r <= 33'(rd_y_r) - 33'(ya_r);
      end
      vsc_pkg::BK_MAG: begin
        adx_r <= adx_w[31:0];
        ady_r <= ady_w[31:0];
        ngx_r <= dx_r[32];
        ngy_r <= dy_r[32];
        sh_r  <= sh_w;
        mx_r  <= sh_w ? adx_w[31:1] : adx_w[30:0];
        my_r  <= sh_w ? ady_w[31:1] : ady_w[30:0];
      end
      vsc_pkg::BK_SQUARE: begin
        sqx_r <= mx_r * mx_r;
        sqy_r <= my_r * my_r;
      end
      vsc_pkg::BK_SUM: begin
        rad_r  <= 63'(sqx_r) + 63'(sqy_r);
        root_r <= '0;
        bit_r  <= 63'd1 << 62;
        cnt_r  <= 6'd31;
      end
      vsc_pkg::BK_SQRT: begin
        if ({1'b0, rad_r} >= sq_t) begin
          rad_r  <= rad_r - sq_t[62:0];
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - 1'b1;
      end
      vsc_pkg::BK_CHECK: begin
        diff_r <= $signed({2'b00, cmd_r.stick_length}) - $signed({1'b0, dist_w});
        den_r  <= {dist_w, 1'b0};
      end
      vsc_pkg::BK_DMAG: begin
        dneg_r <= diff_r[33];
        dmag_r <= diff_r[33] ? 33'(-diff_r) : 33'(diff_r);
      end
      vsc_pkg::BK_PROD_LO: begin
        plx_r <= adx_r * dmag_r[16:0];
        ply_r <= ady_r * dmag_r[16:0];
      end
      vsc_pkg::BK_PROD_HI: begin
        prx_r <= 66'(plx_r) + (66'(adx_r * dmag_r[32:17]) << 17);
        pry_r <= 66'(ply_r) + (66'(ady_r * dmag_r[32:17]) << 17);
      end
      vsc_pkg::BK_DIV_INIT: begin
        ovx_r  <= (34'(prx_r[65:40]) >= den_r);
        ovy_r  <= (34'(pry_r[65:40]) >= den_r);
        remx_r <= (34'(prx_r[65:40]) >= den_r) ? '0 : 34'(prx_r[65:40]);
        remy_r <= (34'(pry_r[65:40]) >= den_r) ? '0 : 34'(pry_r[65:40]);
        qx_r   <= '0;
        qy_r   <= '0;
        cnt_r  <= 6'd39;
      end
      vsc_pkg::BK_DIV: begin
        remx_r <= gx ? 34'(tx - {1'b0, den_r}) : tx[33:0];
        remy_r <= gy ? 34'(ty - {1'b0, den_r}) : ty[33:0];
        qx_r   <= {qx_r[38:0], gx};
        qy_r   <= {qy_r[38:0], gy};
        prx_r  <= prx_r << 1;
        pry_r  <= pry_r << 1;
        cnt_r  <= cnt_r - 1'b1;
      end
      vsc_pkg::BK_APPLY: begin
        nxa_r <= vsc_pkg::sat32(43'(xa_r) - 43'(ox));
        nya_r <= vsc_pkg::sat32(43'(ya_r) - 43'(oy));
        nxb_r <= vsc_pkg::sat32(43'(xb_r) + 43'(ox));
        nyb_r <= vsc_pkg::sat32(43'(yb_r) + 43'(oy));
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for verlet_stick_constraint_core: random and directed requests
// are checked against a built-in model of the particle store and the stick relaxation.
// Depends on vsc_pkg and the core RTL only.
`default_nettype none
module tb;
  import vsc_pkg::*;

  typedef struct {
    op_t         op;
    logic [9:0]  ia;
    logic [9:0]  ib;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] len;
    bit          drain;
  } request_t;

  typedef struct {
    logic [31:0] rx;
    logic [31:0] ry;
    status_t     st;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_operation = '0;
  logic [9:0] in_index_a = '0;
  logic [9:0] in_index_b = '0;
  logic signed [31:0] in_value_x = '0;
  logic signed [31:0] in_value_y = '0;
  logic [31:0] in_stick_length = '0;
  logic out_strobe;
  logic signed [31:0] out_read_x;
  logic signed [31:0] out_read_y;
  logic [1:0] out_status;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  verlet_stick_constraint_core dut (.*);

  initial forever #6 clk = ~clk;

  request_t pending[$];
  answer_t answers_due[$];
  logic signed [31:0] pos_x[1024];
  logic signed [31:0] pos_y[1024];
  logic [10:0] num_particles = '0;
  int errors = 0;
  int accepted = 0;
  int checked = 0;
  int relaxed = 0;
  int cycles = 0;

  // Generator-side view: which particles have been written so far.
  bit written[1024];
  int written_list[$];
  int gen_count = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want, checked);
  endtask

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint stick_offset(input longint dv, input longint diff,
                                          input logic [63:0] den);
    logic [127:0] prod, q;
    logic [63:0] ma, mb;
    ma = dv < 0 ? -dv : dv;
    mb = diff < 0 ? -diff : diff;
    prod = ma * mb;
    q = prod / den;
    if (q > (128'h1 << 40)) q = 128'h1 << 40;
    return ((dv < 0) != (diff < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic bit index_valid(input logic [9:0] i);
    return i < num_particles;
  endfunction

  task automatic stick_relax(input request_t r, output status_t st);
    longint xa, ya, xb, yb, dx, dy, diff, ox, oy;
    logic [63:0] ux, uy, span;
    int s;
    xa = pos_x[r.ia];
    ya = pos_y[r.ia];
    xb = pos_x[r.ib];
    yb = pos_y[r.ib];
    dx = xb - xa;
    dy = yb - ya;
    ux = dx < 0 ? -dx : dx;
    uy = dy < 0 ? -dy : dy;
    s = (ux >= 64'h80000000 || uy >= 64'h80000000) ? 1 : 0;
    ux = ux >> s;
    uy = uy >> s;
    span = isqrt(ux * ux + uy * uy) << s;
    if (span < 64'd66) begin
      st = ST_TOO_CLOSE;
      return;
    end
    diff = longint'({32'd0, r.len}) - longint'(span);
    ox = stick_offset(dx, diff, span * 2);
    oy = stick_offset(dy, diff, span * 2);
    pos_x[r.ia] = clamp32(xa - ox);
    pos_y[r.ia] = clamp32(ya - oy);
    pos_x[r.ib] = clamp32(xb + ox);
    pos_y[r.ib] = clamp32(yb + oy);
    relaxed++;
    st = ST_DONE;
  endtask

  task automatic predict(input request_t r);
    answer_t a;
    a.rx = '0;
    a.ry = '0;
    a.st = ST_DONE;
    case (r.op)
      OP_WRITE, OP_READ: begin
        if (!index_valid(r.ia)) begin
          a.st = ST_BAD_INDEX;
        end else if (r.op == OP_WRITE) begin
          pos_x[r.ia] = r.vx;
          pos_y[r.ia] = r.vy;
        end else begin
          a.rx = pos_x[r.ia];
          a.ry = pos_y[r.ia];
        end
      end
      OP_STICK: begin
        if (!index_valid(r.ia) || !index_valid(r.ib)) a.st = ST_BAD_INDEX;
        else stick_relax(r, a.st);
      end
      default: ;
    endcase
    answers_due.push_back(a);
  endtask

  // Driver: presents queued requests with random gaps between them.
  int gap = 0;
  request_t cur;
  always @(posedge clk) begin
    logic nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      nxt = start;
      if (start && !busy) begin
        predict(cur);
        accepted++;
        void'(pending.pop_front());
        nxt = 1'b0;
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
      end
      if (!nxt) begin
        if (gap > 0) begin
          gap--;
        end else if (pending.size() > 0 && !(pending[0].drain && answers_due.size() > 0)) begin
          cur = pending[0];
          in_operation <= cur.op;
          in_index_a <= cur.ia;
          in_index_b <= cur.ib;
          in_value_x <= cur.vx;
          in_value_y <= cur.vy;
          in_stick_length <= cur.len;
          nxt = 1'b1;
        end
      end
      start <= nxt;
    end
  end

  // Monitor: every strobe is checked against the oldest expected result.
  always @(posedge clk) begin
    answer_t a;
    if (rst_n && out_strobe) begin
      if (answers_due.size() == 0) begin
        report("result with no request outstanding", 32'(out_status), '0);
      end else begin
        a = answers_due.pop_front();
        if (out_read_x !== a.rx) report("read_x", out_read_x, a.rx);
        if (out_read_y !== a.ry) report("read_y", out_read_y, a.ry);
        if (out_status !== a.st) report("status", 32'(out_status), 32'(a.st));
        checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 600000) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic add(input op_t op, input int ia, input int ib, input logic [31:0] vx,
                     input logic [31:0] vy, input logic [31:0] len, input bit drain = 0);
    request_t r;
    r.op = op;
    r.ia = 10'(ia);
    r.ib = 10'(ib);
    r.vx = vx;
    r.vy = vy;
    r.len = len;
    r.drain = drain;
    if (op == OP_WRITE && ia < gen_count && !written[ia]) begin
      written[ia] = 1;
      written_list.push_back(ia);
    end
    pending.push_back(r);
  endtask

  function automatic int pick_written();
    int i;
    for (int t = 0; t < 16; t++) begin
      if (written_list.size() == 0) return -1;
      i = written_list[$urandom_range(0, written_list.size() - 1)];
      if (i < gen_count) return i;
    end
    return -1;
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom() & 32'h000003FF;
      default: return 32'($signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh00FFFFFF);
    endcase
  endfunction

  task automatic add_random(input int n);
    int a, b, kind;
    logic [31:0] len;
    for (int k = 0; k < n; k++) begin
      kind = $urandom_range(0, 19);
      a = pick_written();
      b = pick_written();
      if (kind < 5 || a < 0 || b < 0) begin
        a = (gen_count > 0) ? $urandom_range(0, gen_count - 1) : 0;
        add(OP_WRITE, a, $urandom_range(0, 1023), rand_pos(), rand_pos(), $urandom());
      end else if (kind < 9) begin
        add(OP_READ, a, $urandom_range(0, 1023), $urandom(), $urandom(), $urandom());
      end else if (kind < 18) begin
        case ($urandom_range(0, 3))
          0: len = $urandom();
          1: len = $urandom_range(0, 32'h00FFFFFF);
          default: len = $urandom_range(0, 32'h000FFFFF);
        endcase
        add(OP_STICK, a, b, $urandom(), $urandom(), len);
      end else if (kind == 18) begin
        add(OP_NONE, $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom(),
            $urandom(), $urandom());
      end else begin
        // An index at or beyond the particle count is rejected before any read.
        a = $urandom_range(gen_count < 1024 ? gen_count : 1023, 1023);
        if (gen_count >= 1024) add(OP_NONE, a, a, $urandom(), $urandom(), $urandom());
        else add(op_t'($urandom_range(0, 2)), a, $urandom_range(0, 1023), $urandom(),
                 $urandom(), $urandom());
      end
    end
  endtask

  task automatic wait_idle();
    while (pending.size() > 0 || answers_due.size() > 0 || start) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_count(input int n);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= '0;
    cfg_pwdata <= 32'(n);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    num_particles = 11'(n);
    gen_count = n;
    @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < 1024; i++) begin
      pos_x[i] = '0;
      pos_y[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_count(1024);
    add(OP_WRITE, 0, 1023, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF);
    add(OP_WRITE, 1023, 0, 32'h80000000, 32'h80000000, 32'h0);
    add(OP_READ, 0, 0, 32'h0, 32'h0, 32'h0);
    add(OP_READ, 1023, 1023, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    add(OP_STICK, 0, 1023, 32'h0, 32'h0, 32'h0);
    add(OP_READ, 0, 0, 32'h0, 32'h0, 32'h0);
    add(OP_READ, 1023, 0, 32'h0, 32'h0, 32'h0);
    add(OP_WRITE, 1, 0, 32'h00010000, 32'h00010000, 32'h0);
    add(OP_WRITE, 2, 0, 32'h00010020, 32'h00010020, 32'h0);
    add(OP_STICK, 1, 2, 32'h0, 32'h0, 32'h00010000);
    add(OP_STICK, 1, 1, 32'h0, 32'h0, 32'h00010000);
    add(OP_WRITE, 3, 0, 32'h00010042, 32'h00010000, 32'h0);
    add(OP_STICK, 1, 3, 32'h0, 32'h0, 32'h00020000);
    add(OP_WRITE, 512, 0, 32'h00000000, 32'h00000000, 32'h0);
    add(OP_WRITE, 511, 0, 32'h00300000, 32'hFFD00000, 32'h0);
    add(OP_STICK, 512, 511, 32'h0, 32'h0, 32'hFFFFFFFF);
    add(OP_STICK, 511, 512, 32'h0, 32'h0, 32'h00010000);
    add(OP_READ, 511, 0, 32'h0, 32'h0, 32'h0);
    add(OP_READ, 512, 0, 32'h0, 32'h0, 32'h0);
    add(OP_NONE, 1023, 1023, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    add_random(90);
    add(OP_READ, 0, 0, 32'h0, 32'h0, 32'h0, 1);
    add_random(90);
    wait_idle();

    set_count(0);
    add(OP_WRITE, 0, 0, 32'h1, 32'h1, 32'h0);
    add(OP_READ, 0, 0, 32'h0, 32'h0, 32'h0);
    add(OP_STICK, 0, 1, 32'h0, 32'h0, 32'h0);
    add_random(20);
    wait_idle();

    set_count(2);
    add(OP_READ, 2, 0, 32'h0, 32'h0, 32'h0);
    add(OP_STICK, 0, 2, 32'h0, 32'h0, 32'h0);
    add_random(60);
    wait_idle();

    set_count(700);
    add_random(80);
    wait_idle();

    set_count(1024);
    add_random(140);
    wait_idle();

    $display("Accepted %0d requests and checked %0d results, %0d sticks relaxed,",
             accepted, checked, relaxed);
    $display("over particle counts 1024, 0, 2, 700 and 1024.");
    if (errors == 0 && answers_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> verlet_stick_constraint_core.f
hdl/vsc_pkg.sv
hdl/vsc_front.sv
hdl/vsc_queue.sv
hdl/vsc_back.sv
hdl/verlet_stick_constraint_core.sv
verif/tb.sv
